// ===== hdl/imu_angle_frame_parser_defines.svh =====
// Assertion macros used by the checker file
`ifndef IMU_ANGLE_FRAME_PARSER_DEFINES_SVH
`define IMU_ANGLE_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define IAFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is held
`define IAFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== hdl/iafp_pkg.sv =====
`timescale 1ns / 1ps

package iafp_pkg;

  localparam int BYTE_W      = 8;
  localparam int POS_W       = 4;
  localparam int WORD_W      = 16;
  localparam int ANGLE_COUNT = 6;
  localparam int ANGLE_IDX_W = 3;
  localparam int CFG_IDX_W   = 2;

  // Frame positions: data bytes start at 2, checksum byte sits at 10
  localparam logic [POS_W-1:0] FIRST_DATA_POS = 4'd2;
  localparam logic [POS_W-1:0] ANGLE_END_POS  = 4'd8;
  localparam logic [POS_W-1:0] LAST_POS       = 4'd10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SYNC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TYPE = 2'd1;

  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h55;
  localparam logic [BYTE_W-1:0] TYPE_RESET = 8'h53;

  typedef struct packed {
    logic signed [WORD_W-1:0] roll_raw;
    logic signed [WORD_W-1:0] pitch_raw;
    logic signed [WORD_W-1:0] yaw_raw;
    logic                     checksum_ok;
  } iafp_result_t;

endpackage

// ===== hdl/iafp_parse_core.sv =====
`timescale 1ns / 1ps

module iafp_parse_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [iafp_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [iafp_pkg::BYTE_W-1:0]   sync_byte,
  input  logic [iafp_pkg::BYTE_W-1:0]   type_byte,
  output logic                          res_valid,
  output iafp_pkg::iafp_result_t        res
);
  import iafp_pkg::*;

  logic                   in_frame_r, in_frame_nxt;
  logic [POS_W-1:0]       idx_r, idx_nxt;
  logic [BYTE_W-1:0]      prev_r, prev_prev_r;
  logic [BYTE_W-1:0]      sum_r, sum_nxt;
  logic [BYTE_W-1:0]      angle_r [ANGLE_COUNT];

  logic                   start_c;
  logic                   frame_c;
  logic                   last_c;
  logic                   store_c;
  logic [POS_W-1:0]       pos_c;
  logic [POS_W-1:0]       off_c;
  logic [ANGLE_IDX_W-1:0] store_idx;
  logic [BYTE_W-1:0]      sum_c;
  logic                   ok_c;

  // Detect header, pick effective frame position and running sum
  always_comb begin
    start_c   = !in_frame_r && (prev_r == type_byte) && (prev_prev_r == sync_byte);
    frame_c   = in_frame_r || start_c;
    pos_c     = start_c ? FIRST_DATA_POS : idx_r;
    sum_c     = start_c ? BYTE_W'(sync_byte + type_byte) : sum_r;
    last_c    = frame_c && (pos_c >= LAST_POS);
    store_c   = frame_c && (pos_c >= FIRST_DATA_POS) && (pos_c < ANGLE_END_POS);
    off_c     = pos_c - FIRST_DATA_POS;
    store_idx = off_c[ANGLE_IDX_W-1:0];
    ok_c      = (sum_c == rx_byte);
  end

  // Advance frame position and running sum
  always_comb begin
    in_frame_nxt = frame_c && !last_c;
    sum_nxt      = sum_r;
    idx_nxt      = idx_r;
    if (last_c) begin
      idx_nxt = '0;
    end else if (frame_c) begin
      idx_nxt = pos_c + POS_W'(1);
      sum_nxt = BYTE_W'(sum_c + rx_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      idx_r       <= '0;
      prev_r      <= '0;
      prev_prev_r <= '0;
      sum_r       <= '0;
    end else if (step) begin
      in_frame_r  <= in_frame_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      prev_prev_r <= prev_r;
      prev_r      <= rx_byte;
    end
  end

  // Capture angle data bytes
  always_ff @(posedge clk) begin
    if (step && store_c) begin
      angle_r[store_idx] <= rx_byte;
    end
  end

  // Build the result on the checksum byte; zero the angles on a mismatch
  always_comb begin
    res_valid       = step && last_c;
    res.checksum_ok = ok_c;
    res.roll_raw    = ok_c ? {angle_r[1], angle_r[0]} : '0;
    res.pitch_raw   = ok_c ? {angle_r[3], angle_r[2]} : '0;
    res.yaw_raw     = ok_c ? {angle_r[5], angle_r[4]} : '0;
  end

endmodule

// ===== hdl/iafp_out_reg.sv =====
`timescale 1ns / 1ps

module iafp_out_reg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  iafp_pkg::iafp_result_t  res,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic                    slot_free,
  output iafp_pkg::iafp_result_t  out_res
);
  import iafp_pkg::*;

  logic         valid_r, valid_nxt;
  iafp_result_t res_r;

  // Slot frees when empty or when the held result transfers this cycle
  always_comb begin
    slot_free = !valid_r || !out_stall;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload until the next load
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== hdl/imu_angle_frame_parser.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   in_rx_byte (8)
// out      output     out_valid / out_stall out_roll_raw, out_pitch_raw, out_yaw_raw,
//                                           out_checksum_ok
// cfg      input      cfg_wr_en             cfg_index (2), cfg_wdata (8)
//
// One byte per cycle is taken while the result side is not stalled.
// A byte waits in the input register; when the parser steps, a result loads
// the output register that drives out_valid.
// rst_n is synchronous; it clears frame state, byte history and both valids.
// While a result is held under out_stall, at most one more byte is taken into
// the input register, then in_stall rises until the held result transfers.

module imu_angle_frame_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [iafp_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [iafp_pkg::WORD_W-1:0] out_roll_raw,
  output logic signed [iafp_pkg::WORD_W-1:0] out_pitch_raw,
  output logic signed [iafp_pkg::WORD_W-1:0] out_yaw_raw,
  output logic                          out_checksum_ok,
  input  logic                          cfg_wr_en,
  input  logic [iafp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iafp_pkg::BYTE_W-1:0]   cfg_wdata
);
  import iafp_pkg::*;

  logic              in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] sync_r, sync_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic              accept;
  logic              advance;
  logic              step;
  logic              slot_free;
  logic              res_valid;
  iafp_result_t      res;
  iafp_result_t      out_res;

  // Configuration writes; drop unknown indexes
  always_comb begin
    sync_nxt = sync_r;
    type_nxt = type_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IDX_SYNC: sync_nxt = cfg_wdata;
        CFG_IDX_TYPE: type_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RESET;
      type_r <= TYPE_RESET;
    end else begin
      sync_r <= sync_nxt;
      type_r <= type_nxt;
    end
  end

  // Input register: advance when the result slot is free
  always_comb begin
    advance      = slot_free;
    in_stall     = in_valid_r && !advance;
    accept       = in_valid && !in_stall;
    step         = in_valid_r && advance;
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_rx_byte;
    end
  end

  iafp_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (byte_r),
    .sync_byte (sync_r),
    .type_byte (type_r),
    .res_valid (res_valid),
    .res       (res)
  );

  iafp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .slot_free (slot_free),
    .out_res   (out_res)
  );

  assign out_roll_raw    = out_res.roll_raw;
  assign out_pitch_raw   = out_res.pitch_raw;
  assign out_yaw_raw     = out_res.yaw_raw;
  assign out_checksum_ok = out_res.checksum_ok;

endmodule

// ===== hdl/iafp_checker.sv =====
`timescale 1ns / 1ps
`include "imu_angle_frame_parser_defines.svh"

module iafp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [iafp_pkg::WORD_W-1:0] out_roll_raw,
  input logic signed [iafp_pkg::WORD_W-1:0] out_pitch_raw,
  input logic signed [iafp_pkg::WORD_W-1:0] out_yaw_raw,
  input logic                               out_checksum_ok
);
  import iafp_pkg::*;

  logic [3*WORD_W:0] out_payload;
  logic              out_angles_zero;

  // Gather the result payload for the hold and zero checks
  assign out_payload     = {out_roll_raw, out_pitch_raw, out_yaw_raw, out_checksum_ok};
  assign out_angles_zero = (out_roll_raw == '0) && (out_pitch_raw == '0) &&
                           (out_yaw_raw == '0);

  // A stalled result holds until it transfers
  `IAFP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_payload))

  // A failed checksum carries zero angles
  `IAFP_ASSERT_IMPLY(a_bad_zero, clk, rst_n, out_valid && !out_checksum_ok, out_angles_zero)

  // Input backpressure only comes from a stalled, full result slot
  `IAFP_ASSERT_IMPLY(a_stall_src, clk, rst_n, in_stall, out_valid && out_stall)

  // No result right after reset
  `IAFP_ASSERT_IMPLY(a_rst_empty, clk, rst_n, $past(!rst_n), !out_valid)

endmodule

bind imu_angle_frame_parser iafp_checker u_iafp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_roll_raw    (out_roll_raw),
  .out_pitch_raw   (out_pitch_raw),
  .out_yaw_raw     (out_yaw_raw),
  .out_checksum_ok (out_checksum_ok)
);
